// ----- hdl/ope_pkg.sv -----
// Shared codes, field widths and default sizes for the observation propagation engine.
package ope_pkg;

    // Fixed field widths of the item and result beats
    localparam int KIND_W   = 3;
    localparam int VTX_W    = 10;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 11;

    // Default sizes
    localparam int DEF_VERTEX_COUNT = 1024;
    localparam int DEF_MAX_DEGREE   = 16;
    localparam int DEF_STACK_DEPTH  = 2048;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD_EDGE = 3'd0,
        KIND_SET_MARK = 3'd1,
        KIND_INIT     = 3'd2,
        KIND_STASH    = 3'd3,
        KIND_RESTORE  = 3'd4,
        KIND_OBSERVE  = 3'd5
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ROW_FULL = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

endpackage

// ----- hdl/ope_item_if.sv -----
// Item and result channel interfaces of the observation propagation engine.
interface ope_item_if import ope_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [VTX_W-1:0]  vertex_a;
    logic [VTX_W-1:0]  vertex_b;
    logic              mark_value;

    modport source (output valid, kind, vertex_a, vertex_b, mark_value, input ready);
    modport sink   (input valid, kind, vertex_a, vertex_b, mark_value, output ready);
endinterface

interface ope_result_if import ope_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    observed_count;
    logic [CNT_W-1:0]    newly_observed;

    modport source (output valid, status, observed_count, newly_observed, input ready);
    modport sink   (input valid, status, observed_count, newly_observed, output ready);
endinterface

// ----- hdl/ope_ram.sv -----
// Generic single write port RAM with one registered read port.
module ope_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/observation_propagation_engine_unit.sv -----
// Top level of the observation propagation engine: sequencer around five RAMs.
//
//  channel | direction | beat contents
//  --------+-----------+-------------------------------------------------
//  item    | in        | kind, vertex_a, vertex_b, mark_value
//  result  | out       | status, observed_count, newly_observed
//
// One item at a time; every RAM read is registered.
// Add edge: read the row length, compare each entry of the source row, then append.
// Set mark: read, then write the vertex state. Initialize, stash, restore: a read
// and a write per vertex. Observe: read each vertex looked at, then for a newly
// observed one decrement each row entry; pop each worklist entry and, when it
// forces, look at each entry of its row.
// After reset a clearing pass over every vertex runs with item.ready low.
// A result waits in an output register; the next item is taken meanwhile.
module observation_propagation_engine_unit import ope_pkg::*; #(
    parameter int VERTEX_COUNT = DEF_VERTEX_COUNT,
    parameter int MAX_DEGREE   = DEF_MAX_DEGREE,
    parameter int STACK_DEPTH  = DEF_STACK_DEPTH
) (
    input  logic  clk,
    input  logic  rst_n,
    ope_item_if.sink     item,
    ope_result_if.source result
);
    localparam int VW  = $clog2(VERTEX_COUNT);
    localparam int IW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int LW  = $clog2(MAX_DEGREE + 1);
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int TW  = $clog2(STACK_DEPTH + 1);
    localparam int ADJ_DEPTH = VERTEX_COUNT << IW;

    typedef struct packed {
        logic          np;
        logic          obs;
        logic [LW-1:0] deg;
    } vstate_t;

    typedef enum logic [4:0] {
        IDLE, CLEAR,
        A_RD, A_LEN, A_SCAN, A_CMP, A_END,
        K_RD, K_WR,
        W_RD, W_WR,
        M_RD, M_CHK, M_ADJ, M_ADJW, M_DEC,
        F_POP, F_POPW, F_CHK, F_ADJ, F_ADJW,
        DONE
    } state_t;

    state_t         state_reg, state_next;
    logic [VW-1:0]  va_reg, va_next, vb_reg, vb_next;
    logic           mv_reg, mv_next;
    kind_t          sweep_reg, sweep_next;
    logic [VW-1:0]  x_reg, x_next, w_reg, w_next, v_reg, v_next, ctr_reg, ctr_next;
    logic [LW-1:0]  mi_reg, mi_next, mn_reg, mn_next, fi_reg, fi_next, fn_reg, fn_next;
    logic [TW-1:0]  top_reg, top_next;
    logic           ovf_reg, ovf_next, infix_reg, infix_next;
    status_t        status_reg, status_next;
    logic [CNT_W-1:0] total_reg, total_next, fresh_reg, fresh_next;
    logic           out_valid_reg, out_valid_next;
    status_t        out_status_reg, out_status_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next, out_fresh_reg, out_fresh_next;

    // RAM ports
    logic                  vs_we, rl_we, sv_we, adj_we, wl_we;
    logic [VW-1:0]         vs_waddr, vs_raddr, rl_waddr, rl_raddr, sv_waddr, sv_raddr;
    vstate_t               vs_wdata, vs_q;
    logic [LW-1:0]         rl_wdata, rl_q, sv_wdata, sv_q;
    logic [VW+IW-1:0]      adj_waddr, adj_raddr;
    logic [VW-1:0]         adj_wdata, adj_q;
    logic [AW-1:0]         wl_waddr, wl_raddr;
    logic [VW-1:0]         wl_wdata, wl_q;

    logic                  push_req;
    logic [VW-1:0]         push_v;
    logic [TW-1:0]         top_dec;
    logic [LW-1:0]         deg_dec;
    logic                  a_ok, b_ok;

    ope_ram #(.WIDTH($bits(vstate_t)), .DEPTH(VERTEX_COUNT)) u_vs (
        .clk(clk), .we(vs_we), .waddr(vs_waddr), .wdata(vs_wdata),
        .raddr(vs_raddr), .rdata(vs_q));
    ope_ram #(.WIDTH(LW), .DEPTH(VERTEX_COUNT)) u_rl (
        .clk(clk), .we(rl_we), .waddr(rl_waddr), .wdata(rl_wdata),
        .raddr(rl_raddr), .rdata(rl_q));
    ope_ram #(.WIDTH(LW), .DEPTH(VERTEX_COUNT)) u_sv (
        .clk(clk), .we(sv_we), .waddr(sv_waddr), .wdata(sv_wdata),
        .raddr(sv_raddr), .rdata(sv_q));
    ope_ram #(.WIDTH(VW), .DEPTH(ADJ_DEPTH)) u_adj (
        .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
        .raddr(adj_raddr), .rdata(adj_q));
    ope_ram #(.WIDTH(VW), .DEPTH(STACK_DEPTH)) u_wl (
        .clk(clk), .we(wl_we), .waddr(wl_waddr), .wdata(wl_wdata),
        .raddr(wl_raddr), .rdata(wl_q));

    assign item.ready          = (state_reg == IDLE);
    assign result.valid        = out_valid_reg;
    assign result.status       = out_status_reg;
    assign result.observed_count = out_count_reg;
    assign result.newly_observed = out_fresh_reg;

    assign a_ok    = int'(item.vertex_a) < VERTEX_COUNT;
    assign b_ok    = int'(item.vertex_b) < VERTEX_COUNT;
    assign top_dec = top_reg - TW'(1);
    assign deg_dec = (vs_q.deg != '0) ? vs_q.deg - LW'(1) : vs_q.deg;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        va_next     = va_reg;
        vb_next     = vb_reg;
        mv_next     = mv_reg;
        sweep_next  = sweep_reg;
        x_next      = x_reg;
        w_next      = w_reg;
        v_next      = v_reg;
        ctr_next    = ctr_reg;
        mi_next     = mi_reg;
        mn_next     = mn_reg;
        fi_next     = fi_reg;
        fn_next     = fn_reg;
        top_next    = top_reg;
        ovf_next    = ovf_reg;
        infix_next  = infix_reg;
        status_next = status_reg;
        total_next  = total_reg;
        fresh_next  = fresh_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_fresh_next  = out_fresh_reg;

        vs_we = 1'b0; vs_waddr = x_reg; vs_wdata = vs_q; vs_raddr = x_reg;
        rl_we = 1'b0; rl_waddr = va_reg; rl_wdata = mn_reg; rl_raddr = va_reg;
        sv_we = 1'b0; sv_waddr = ctr_reg; sv_wdata = vs_q.deg; sv_raddr = ctr_reg;
        adj_we = 1'b0; adj_waddr = {va_reg, mn_reg[IW-1:0]}; adj_wdata = vb_reg;
        adj_raddr = {x_reg, mi_reg[IW-1:0]};
        wl_we = 1'b0; wl_waddr = top_reg[AW-1:0]; wl_wdata = x_reg;
        wl_raddr = top_dec[AW-1:0];
        push_req = 1'b0;
        push_v   = x_reg;

        // result register drains independently
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            IDLE:
            begin
                if (item.valid)
                begin
                    va_next     = VW'(item.vertex_a);
                    vb_next     = VW'(item.vertex_b);
                    mv_next     = item.mark_value;
                    x_next      = VW'(item.vertex_a);
                    status_next = STATUS_OK;
                    fresh_next  = '0;
                    ovf_next    = 1'b0;
                    infix_next  = 1'b0;
                    ctr_next    = '0;
                    sweep_next  = kind_t'(item.kind);
                    state_next  = DONE;
                    unique case (item.kind) inside
                        KIND_ADD_EDGE: if (a_ok && b_ok) state_next = A_RD;
                        KIND_SET_MARK: if (a_ok) state_next = K_RD;
                        KIND_INIT, KIND_STASH, KIND_RESTORE: state_next = W_RD;
                        KIND_OBSERVE:  if (a_ok) state_next = M_RD;
                        default:       state_next = DONE;
                    endcase
                end
            end
            CLEAR:
            begin
                vs_we = 1'b1; vs_waddr = ctr_reg; vs_wdata = '0;
                rl_we = 1'b1; rl_waddr = ctr_reg; rl_wdata = '0;
                sv_we = 1'b1; sv_waddr = ctr_reg; sv_wdata = '0;
                ctr_next = ctr_reg + VW'(1);
                if (ctr_reg == VW'(VERTEX_COUNT - 1))
                begin
                    state_next = IDLE;
                end
            end
            // add edge: scan the row for a duplicate, then append
            A_RD:
            begin
                state_next = A_LEN;
            end
            A_LEN:
            begin
                mn_next    = rl_q;
                mi_next    = '0;
                state_next = A_SCAN;
            end
            A_SCAN:
            begin
                adj_raddr = {va_reg, mi_reg[IW-1:0]};
                state_next = (mi_reg == mn_reg) ? A_END : A_CMP;
            end
            A_CMP:
            begin
                if (adj_q == vb_reg)
                begin
                    state_next = DONE;
                end
                else
                begin
                    mi_next    = mi_reg + LW'(1);
                    state_next = A_SCAN;
                end
            end
            A_END:
            begin
                if (int'(mn_reg) >= MAX_DEGREE)
                begin
                    status_next = STATUS_ROW_FULL;
                end
                else
                begin
                    adj_we   = 1'b1;
                    rl_we    = 1'b1;
                    rl_wdata = mn_reg + LW'(1);
                end
                state_next = DONE;
            end
            // set the non-propagating mark
            K_RD:
            begin
                vs_raddr   = va_reg;
                state_next = K_WR;
            end
            K_WR:
            begin
                vs_we       = 1'b1;
                vs_waddr    = va_reg;
                vs_wdata    = vs_q;
                vs_wdata.np = mv_reg;
                state_next  = DONE;
            end
            // whole-table sweeps
            W_RD:
            begin
                vs_raddr   = ctr_reg;
                rl_raddr   = ctr_reg;
                sv_raddr   = ctr_reg;
                state_next = W_WR;
            end
            W_WR:
            begin
                vs_waddr = ctr_reg;
                case (sweep_reg)
                    KIND_INIT:
                    begin
                        vs_we        = 1'b1;
                        vs_wdata.obs = 1'b0;
                        vs_wdata.deg = rl_q;
                        total_next   = '0;
                    end
                    KIND_STASH:
                    begin
                        sv_we = 1'b1;
                    end
                    default:
                    begin
                        vs_we        = 1'b1;
                        vs_wdata.deg = sv_q;
                    end
                endcase
                ctr_next   = ctr_reg + VW'(1);
                state_next = (ctr_reg == VW'(VERTEX_COUNT - 1)) ? DONE : W_RD;
            end
            // observe one vertex and decrement its neighbors
            M_RD:
            begin
                vs_raddr   = x_reg;
                rl_raddr   = x_reg;
                state_next = M_CHK;
            end
            M_CHK:
            begin
                if (vs_q.obs)
                begin
                    if (infix_reg)
                    begin
                        fi_next    = fi_reg + LW'(1);
                        state_next = F_ADJ;
                    end
                    else
                    begin
                        state_next = F_POP;
                    end
                end
                else
                begin
                    vs_we        = 1'b1;
                    vs_waddr     = x_reg;
                    vs_wdata.obs = 1'b1;
                    total_next   = total_reg + CNT_W'(1);
                    fresh_next   = fresh_reg + CNT_W'(1);
                    push_req     = (vs_q.deg == LW'(1));
                    push_v       = x_reg;
                    mn_next      = rl_q;
                    mi_next      = '0;
                    state_next   = M_ADJ;
                end
            end
            M_ADJ:
            begin
                adj_raddr = {x_reg, mi_reg[IW-1:0]};
                if (mi_reg == mn_reg)
                begin
                    if (infix_reg)
                    begin
                        fi_next    = fi_reg + LW'(1);
                        state_next = F_ADJ;
                    end
                    else
                    begin
                        state_next = F_POP;
                    end
                end
                else
                begin
                    state_next = M_ADJW;
                end
            end
            M_ADJW:
            begin
                w_next     = adj_q;
                vs_raddr   = adj_q;
                state_next = M_DEC;
            end
            M_DEC:
            begin
                vs_we        = 1'b1;
                vs_waddr     = w_reg;
                vs_wdata.deg = deg_dec;
                push_req     = (deg_dec == LW'(1)) && vs_q.obs && !vs_q.np;
                push_v       = w_reg;
                mi_next      = mi_reg + LW'(1);
                state_next   = M_ADJ;
            end
            // worklist fixpoint
            F_POP:
            begin
                if (top_reg == '0)
                begin
                    state_next = DONE;
                end
                else
                begin
                    top_next   = top_dec;
                    state_next = F_POPW;
                end
            end
            F_POPW:
            begin
                v_next     = wl_q;
                vs_raddr   = wl_q;
                rl_raddr   = wl_q;
                state_next = F_CHK;
            end
            F_CHK:
            begin
                if (!vs_q.obs || vs_q.np || vs_q.deg != LW'(1))
                begin
                    state_next = F_POP;
                end
                else
                begin
                    fn_next    = rl_q;
                    fi_next    = '0;
                    state_next = F_ADJ;
                end
            end
            F_ADJ:
            begin
                adj_raddr = {v_reg, fi_reg[IW-1:0]};
                state_next = (fi_reg == fn_reg) ? F_POP : F_ADJW;
            end
            F_ADJW:
            begin
                x_next     = adj_q;
                infix_next = 1'b1;
                state_next = M_RD;
            end
            DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ovf_reg ? STATUS_OVERFLOW : status_reg;
                    out_count_next  = total_reg;
                    out_fresh_next  = fresh_reg;
                    state_next      = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase

        // worklist push, dropped when full
        if (push_req)
        begin
            if (top_reg == TW'(STACK_DEPTH))
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                wl_we    = 1'b1;
                wl_wdata = push_v;
                top_next = top_reg + TW'(1);
            end
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= CLEAR;
            va_reg         <= '0;
            vb_reg         <= '0;
            mv_reg         <= 1'b0;
            sweep_reg      <= KIND_ADD_EDGE;
            x_reg          <= '0;
            w_reg          <= '0;
            v_reg          <= '0;
            ctr_reg        <= '0;
            mi_reg         <= '0;
            mn_reg         <= '0;
            fi_reg         <= '0;
            fn_reg         <= '0;
            top_reg        <= '0;
            ovf_reg        <= 1'b0;
            infix_reg      <= 1'b0;
            status_reg     <= STATUS_OK;
            total_reg      <= '0;
            fresh_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_OK;
            out_count_reg  <= '0;
            out_fresh_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            va_reg         <= va_next;
            vb_reg         <= vb_next;
            mv_reg         <= mv_next;
            sweep_reg      <= sweep_next;
            x_reg          <= x_next;
            w_reg          <= w_next;
            v_reg          <= v_next;
            ctr_reg        <= ctr_next;
            mi_reg         <= mi_next;
            mn_reg         <= mn_next;
            fi_reg         <= fi_next;
            fn_reg         <= fn_next;
            top_reg        <= top_next;
            ovf_reg        <= ovf_next;
            infix_reg      <= infix_next;
            status_reg     <= status_next;
            total_reg      <= total_next;
            fresh_reg      <= fresh_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= out_count_next;
            out_fresh_reg  <= out_fresh_next;
        end
    end

    // Checks
    a_top_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == IDLE |-> top_reg == '0)
        else $error("worklist not empty between items");

    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= TW'(STACK_DEPTH))
        else $error("worklist pointer beyond depth");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> state_reg != IDLE)
        else $error("sequencer idle right after an accepted beat");

    a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == DONE && state_next == IDLE |=> out_valid_reg)
        else $error("finished item produced no result beat");

endmodule
